// ===== rtl/lpfd_pkg.sv =====
`timescale 1ns / 1ps
// lpfd_pkg: types and constants shared by the length prefixed frame deframer
// used by lpfd_core, lpfd_outbuf and length_prefixed_frame_deframer; no dependencies

package lpfd_pkg;

   // parse phase, one-hot
   typedef enum logic [4:0] {
      PH_HEADER   = 5'b00001,
      PH_FRAMELEN = 5'b00010,
      PH_FWDLEN   = 5'b00100,
      PH_FWDDATA  = 5'b01000,
      PH_PAYLOAD  = 5'b10000
   } phase_type;

   // section codes carried with every byte
   localparam logic [1:0] SecHeader  = 2'd0;
   localparam logic [1:0] SecLength  = 2'd1;
   localparam logic [1:0] SecForward = 2'd2;
   localparam logic [1:0] SecPayload = 2'd3;

   // header byte fields
   localparam logic [7:0] FwdSizeMask = 8'd12;
   localparam logic [7:0] LenSizeMask = 8'd3;

   // configuration register indexes
   localparam logic [0:0] RegLengthsBigEndian = 1'b0;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  section;
      logic [3:0]  package_type;
      logic [31:0] payload_length;
      logic [23:0] forward_length;
      logic        lengths_valid;
      logic        frame_end;
   } rsp_type;

endpackage

// ===== rtl/lpfd_core.sv =====
`timescale 1ns / 1ps
// lpfd_core: frame parse state and the per-byte decode of section and lengths
// depends on lpfd_pkg

module lpfd_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             big_endian,
   output lpfd_pkg::rsp_type result
);
   import lpfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  frame_len_size_ff, frame_len_size_in;
   logic [1:0]  fwd_len_size_ff, fwd_len_size_in;
   logic [1:0]  field_byte_index_ff, field_byte_index_in;
   logic [3:0]  type_ff, type_in;
   logic [31:0] payload_len_ff, payload_len_in;
   logic [23:0] forward_len_ff, forward_len_in;
   logic [31:0] bytes_left_ff, bytes_left_in;

   logic [2:0]  idx_next;
   logic [1:0]  fwd_idx;
   logic [31:0] pl_shift;
   logic [23:0] fl_shift;
   logic [31:0] bytes_dec;
   logic [7:0]  fwd_bits;
   logic [7:0]  len_bits;
   logic        done;
   logic        valid;
   logic        frame_end;
   logic [1:0]  section;

   always_comb begin
      phase_in            = phase_ff;
      frame_len_size_in   = frame_len_size_ff;
      fwd_len_size_in     = fwd_len_size_ff;
      field_byte_index_in = field_byte_index_ff;
      type_in             = type_ff;
      payload_len_in      = payload_len_ff;
      forward_len_in      = forward_len_ff;
      bytes_left_in       = bytes_left_ff;
      section             = SecHeader;
      valid               = 1'b0;
      frame_end           = 1'b0;
      done                = 1'b0;

      idx_next  = {1'b0, field_byte_index_ff} + 3'd1;
      fwd_idx   = (field_byte_index_ff == 2'd3) ? 2'd0 : field_byte_index_ff;
      pl_shift  = {24'd0, data_byte} << {field_byte_index_ff, 3'b000};
      fl_shift  = {16'd0, data_byte} << {fwd_idx, 3'b000};
      bytes_dec = bytes_left_ff - 32'd1;
      fwd_bits  = data_byte & FwdSizeMask;
      len_bits  = data_byte & LenSizeMask;

      case (phase_ff)
         PH_FRAMELEN: begin
            section = SecLength;
            if (big_endian) begin
               payload_len_in = {payload_len_ff[23:0], data_byte};
            end else begin
               payload_len_in = payload_len_ff | pl_shift;
            end
            if (idx_next >= frame_len_size_ff) begin
               field_byte_index_in = 2'd0;
               if (fwd_len_size_ff != 2'd0) begin
                  phase_in = PH_FWDLEN;
               end else begin
                  valid = 1'b1;
                  done  = 1'b1;
               end
            end else begin
               field_byte_index_in = idx_next[1:0];
            end
         end
         PH_FWDLEN: begin
            section = SecLength;
            if (big_endian) begin
               forward_len_in = {forward_len_ff[15:0], data_byte};
            end else begin
               forward_len_in = forward_len_ff | fl_shift;
            end
            if (idx_next >= {1'b0, fwd_len_size_ff}) begin
               field_byte_index_in = 2'd0;
               valid               = 1'b1;
               done                = 1'b1;
            end else begin
               field_byte_index_in = idx_next[1:0];
            end
         end
         PH_FWDDATA: begin
            section       = SecForward;
            valid         = 1'b1;
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) begin
               if (payload_len_ff != 32'd0) begin
                  phase_in      = PH_PAYLOAD;
                  bytes_left_in = payload_len_ff;
               end else begin
                  phase_in  = PH_HEADER;
                  frame_end = 1'b1;
               end
            end
         end
         PH_PAYLOAD: begin
            section       = SecPayload;
            valid         = 1'b1;
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) begin
               phase_in  = PH_HEADER;
               frame_end = 1'b1;
            end
         end
         default: begin
            // header byte, also taken for any phase code with no meaning
            section             = SecHeader;
            type_in             = data_byte[7:4];
            fwd_len_size_in     = fwd_bits[3:2];
            frame_len_size_in   = 3'd1 + {1'b0, len_bits[1:0]};
            field_byte_index_in = 2'd0;
            payload_len_in      = 32'd0;
            forward_len_in      = 24'd0;
            bytes_left_in       = 32'd0;
            phase_in            = PH_FRAMELEN;
         end
      endcase

      // all length bytes in: skip empty sections
      if (done) begin
         if (forward_len_in != 24'd0) begin
            phase_in      = PH_FWDDATA;
            bytes_left_in = {8'd0, forward_len_in};
         end else if (payload_len_in != 32'd0) begin
            phase_in      = PH_PAYLOAD;
            bytes_left_in = payload_len_in;
         end else begin
            phase_in  = PH_HEADER;
            frame_end = 1'b1;
         end
      end

      result.out_byte       = data_byte;
      result.section        = section;
      result.package_type   = type_in;
      result.payload_length = valid ? payload_len_in : 32'd0;
      result.forward_length = valid ? forward_len_in : 24'd0;
      result.lengths_valid  = valid;
      result.frame_end      = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_HEADER;
         frame_len_size_ff   <= 3'd0;
         fwd_len_size_ff     <= 2'd0;
         field_byte_index_ff <= 2'd0;
         type_ff             <= 4'd0;
         payload_len_ff      <= 32'd0;
         forward_len_ff      <= 24'd0;
         bytes_left_ff       <= 32'd0;
      end else if (accept) begin
         phase_ff            <= phase_in;
         frame_len_size_ff   <= frame_len_size_in;
         fwd_len_size_ff     <= fwd_len_size_in;
         field_byte_index_ff <= field_byte_index_in;
         type_ff             <= type_in;
         payload_len_ff      <= payload_len_in;
         forward_len_ff      <= forward_len_in;
         bytes_left_ff       <= bytes_left_in;
      end
   end

endmodule

// ===== rtl/lpfd_outbuf.sv =====
`timescale 1ns / 1ps
// lpfd_outbuf: result register with a skid stage behind it
// depends on lpfd_pkg

module lpfd_outbuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lpfd_pkg::rsp_type push_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output lpfd_pkg::rsp_type out_data
);
   import lpfd_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_free;

   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         // result register held by the receiver, park the transfer
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

// ===== rtl/length_prefixed_frame_deframer.sv =====
`timescale 1ns / 1ps
// length_prefixed_frame_deframer: top level, configuration port and assertions
// depends on lpfd_pkg, lpfd_core and lpfd_outbuf
//
// Takes a framed byte stream on the req_ channel, one byte per transfer, and
// returns one rsp_ transfer per byte: the byte itself, its section (header,
// length field, forward data, payload), the frame's package type, the decoded
// lengths once all length bytes are in, and a flag on the last byte of a frame.
// A frame is a header byte, a payload length field of 1 to 4 bytes, a forward
// length field of 0 to 3 bytes, the forward data and then the payload.
// Byte order of the length fields is set by the register at address 0 of the
// csr_ port; write it only while the block is idle.
// Results are registered; throughput is one byte per cycle while req_stall is
// low, set by the parse state that updates once per byte.
// A two-entry result buffer lets the block take one more byte while the
// receiver stalls; req_stall rises only when both entries are full.
// Reset returns the parser to waiting for a header byte, empties the result
// buffer and clears the byte order register to little endian.

module length_prefixed_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_section,
   output logic [3:0]  rsp_package_type,
   output logic [31:0] rsp_payload_length,
   output logic [23:0] rsp_forward_length,
   output logic        rsp_lengths_valid,
   output logic        rsp_frame_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lpfd_pkg::*;

   logic    big_endian_ff;
   logic    csr_write;
   logic    accept;
   logic    buf_full;
   rsp_type core_result;
   rsp_type out_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else if (csr_write && csr_paddr[2] == RegLengthsBigEndian) begin
         big_endian_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == RegLengthsBigEndian) ? {31'd0, big_endian_ff} : 32'd0;

   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   lpfd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .big_endian (big_endian_ff),
      .result     (core_result)
   );

   lpfd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_out_byte       = out_data.out_byte;
   assign rsp_section        = out_data.section;
   assign rsp_package_type   = out_data.package_type;
   assign rsp_payload_length = out_data.payload_length;
   assign rsp_forward_length = out_data.forward_length;
   assign rsp_lengths_valid  = out_data.lengths_valid;
   assign rsp_frame_end      = out_data.frame_end;

   // the skid entry only fills behind a held result
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_end_has_lengths: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_lengths_valid)
      else $error("frame end before lengths decoded");

   a_header_no_lengths: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_section == SecHeader) |-> (!rsp_lengths_valid && !rsp_frame_end))
      else $error("header byte carries lengths or frame end");

   a_lengths_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_lengths_valid) |->
         (rsp_payload_length == 32'd0 && rsp_forward_length == 24'd0))
      else $error("lengths shown before all length bytes are in");

   a_stall_holds_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_section) && $stable(rsp_frame_end)))
      else $error("stalled result changed");

endmodule
